/* src/ecov_pkg.sv */
// Shared widths and constants for the exponential covariance kernel.
`timescale 1ns / 1ps
`default_nettype none

package ecov_pkg;

    localparam int unsigned COORD_W   = 32;   // signed point coordinate
    localparam int unsigned MAG_W     = 33;   // magnitude of a coordinate difference
    localparam int unsigned REG_W     = 24;   // config register / result width
    localparam int unsigned SQ_W      = 64;   // sum of squares
    localparam int unsigned ROOT_W    = 32;   // integer square root
    localparam int unsigned DIST_W    = 33;   // distance after undoing the pre-shift
    localparam int unsigned T_W       = REG_W + DIST_W;  // phi * distance
    localparam int unsigned FAR_LOG2  = 5;    // far cutoff is 2^5 = 32.0
    localparam int unsigned T32_W     = 32 + FAR_LOG2;   // exponent in Q.32 below cutoff
    localparam int unsigned K_W       = 6;    // ln2 multiples below the cutoff
    localparam int unsigned FRAC_W    = 32;   // reduced exponent in Q.32
    localparam int unsigned E_W       = 33;   // exp value in Q.32, up to 1.0
    localparam int unsigned SUM_W     = 36;   // signed series accumulator
    localparam int unsigned P_W       = REG_W + E_W;     // sigma_sq * exp
    localparam int unsigned TERMS     = 13;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [FRAC_W-1:0] LN2_Q32 = 32'd2977044472;
    localparam logic [E_W-1:0]    ONE_Q32 = 33'h1_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGMA_SQ   = 2'd0,
        CFG_DECAY_RATE = 2'd1
    } t_cfg_idx;

endpackage

`default_nettype wire

/* src/ecov_if.sv */
// Request channels of the kernel: point pairs in, covariance out, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface ecov_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ecov_pkg::COORD_W-1:0] a_x;
    logic signed [ecov_pkg::COORD_W-1:0] a_y;
    logic signed [ecov_pkg::COORD_W-1:0] b_x;
    logic signed [ecov_pkg::COORD_W-1:0] b_y;
    modport source (output valid, a_x, a_y, b_x, b_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, output ready);
endinterface

interface ecov_out_if;
    logic                          valid;
    logic                          ready;
    logic [ecov_pkg::REG_W-1:0]    covariance;
    modport source (output valid, covariance, input ready);
    modport sink   (input valid, covariance, output ready);
endinterface

interface ecov_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ecov_pkg::CFG_IDX_W-1:0]  index;
    logic [ecov_pkg::REG_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/exponential_covariance_kernel_core.sv */
// Top level: streaming exponential covariance sigma_sq * exp(-phi * |a - b|).
//
//  channel  modport  fields                     meaning
//  i_in     sink     a_x, a_y, b_x, b_y (s32)   point pair, Q15.16
//  o_out    source   covariance (u24)           kernel value, Q8.16, saturated
//  i_cfg    sink     index (2), data (u24)      0: sigma_sq, 1: decay_rate
//
// One pair per clock while o_out is not stalled; stages: 3 front, 32 square-root
// bit stages, 8 exponent-reduction stages, 40 series stages, 2 scaling stages.
// The 32-stage square root and the 13-term series set the depth.
// Synchronous active-low reset clears valid bits and loads both registers with 1.0.
// A request left unread on o_out freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module exponential_covariance_kernel_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ecov_in_if.sink        i_in,
    ecov_out_if.source     o_out,
    ecov_cfg_if.sink       i_cfg
);
    import ecov_pkg::*;

    logic [REG_W-1:0] r_sigma_sq;
    logic [REG_W-1:0] r_decay;
    logic             w_en;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma_sq <= REG_W'(1) << FRAC_BITS;
            r_decay    <= REG_W'(1) << FRAC_BITS;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_SIGMA_SQ:   r_sigma_sq <= i_cfg.data;
                CFG_DECAY_RATE: r_decay    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // advance everything unless a result is stuck at the output
    logic r_out_valid;
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // front end: magnitudes, pre-shift and squares, sum
    logic [MAG_W-1:0] w_dxp, w_dxn, w_dyp, w_dyn;
    logic             r_f1_valid, r_f2_valid, r_f3_valid;
    logic [MAG_W-1:0] r_f1_ux, r_f1_uy;
    logic             w_half;
    logic [31:0]      w_ax, w_ay;
    logic [SQ_W-1:0]  r_f2_sx, r_f2_sy;
    logic             r_f2_half, r_f3_half;
    logic [SQ_W-1:0]  r_f3_sum;

    assign w_dxp = {i_in.a_x[COORD_W-1], i_in.a_x} - {i_in.b_x[COORD_W-1], i_in.b_x};
    assign w_dxn = {i_in.b_x[COORD_W-1], i_in.b_x} - {i_in.a_x[COORD_W-1], i_in.a_x};
    assign w_dyp = {i_in.a_y[COORD_W-1], i_in.a_y} - {i_in.b_y[COORD_W-1], i_in.b_y};
    assign w_dyn = {i_in.b_y[COORD_W-1], i_in.b_y} - {i_in.a_y[COORD_W-1], i_in.a_y};

    // halve both when either reaches 2^31 so the squares stay in 64 bits
    assign w_half = r_f1_ux[MAG_W-1] | r_f1_ux[MAG_W-2] | r_f1_uy[MAG_W-1] | r_f1_uy[MAG_W-2];
    assign w_ax   = w_half ? r_f1_ux[MAG_W-1:1] : r_f1_ux[MAG_W-2:0];
    assign w_ay   = w_half ? r_f1_uy[MAG_W-1:1] : r_f1_uy[MAG_W-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (w_en) begin
            r_f1_valid <= i_in.valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // pick the side by signed compare: the difference can reach 2^32 - 1
            r_f1_ux   <= ($signed(i_in.a_x) < $signed(i_in.b_x)) ? w_dxn : w_dxp;
            r_f1_uy   <= ($signed(i_in.a_y) < $signed(i_in.b_y)) ? w_dyn : w_dyp;
            r_f2_sx   <= SQ_W'(w_ax) * SQ_W'(w_ax);
            r_f2_sy   <= SQ_W'(w_ay) * SQ_W'(w_ay);
            r_f2_half <= w_half;
            r_f3_sum  <= r_f2_sx + r_f2_sy;
            r_f3_half <= r_f2_half;
        end
    end

    // square root
    logic              w_q_valid, w_q_half;
    logic [ROOT_W-1:0] w_root;
    logic [DIST_W-1:0] w_dist;

    ecov_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_f3_valid),
        .i_value (r_f3_sum),
        .i_half  (r_f3_half),
        .o_valid (w_q_valid),
        .o_root  (w_root),
        .o_half  (w_q_half)
    );

    assign w_dist = w_q_half ? {w_root, 1'b0} : {1'b0, w_root};

    // exponent reduction
    logic              w_rd_valid, w_rd_far;
    logic [FRAC_W-1:0] w_rd_r;
    logic [K_W-1:0]    w_rd_k;

    ecov_reduce #(
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_decay (r_decay),
        .i_valid (w_q_valid),
        .i_dist  (w_dist),
        .o_valid (w_rd_valid),
        .o_r     (w_rd_r),
        .o_k     (w_rd_k),
        .o_far   (w_rd_far)
    );

    // exp(-r)
    logic           w_ex_valid, w_ex_far;
    logic [E_W-1:0] w_ex_e;
    logic [K_W-1:0] w_ex_k;

    ecov_series u_series (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rd_valid),
        .i_r     (w_rd_r),
        .i_k     (w_rd_k),
        .i_far   (w_rd_far),
        .o_valid (w_ex_valid),
        .o_e     (w_ex_e),
        .o_k     (w_ex_k),
        .o_far   (w_ex_far)
    );

    // scale by sigma_sq, shift by 32 + k with rounding, saturate
    logic           r_b1_valid, r_b1_far;
    logic [K_W-1:0] r_b1_k;
    logic [P_W-1:0] r_b1_p;
    logic [REG_W+1:0] w_p31, w_pr, w_round;
    logic [REG_W-1:0] r_out_cov;

    assign w_p31   = r_b1_p[P_W-1:31];
    assign w_pr    = w_p31 >> r_b1_k[K_W-2:0];
    assign w_round = (REG_W+2)'(w_pr[REG_W+1:1]) + (REG_W+2)'(w_pr[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_valid  <= w_ex_valid;
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_p   <= P_W'(r_sigma_sq) * P_W'(w_ex_e);
            r_b1_k   <= w_ex_k;
            r_b1_far <= w_ex_far;
            // shift of 64 or more, or exponent past the cutoff: zero
            if (r_b1_far || r_b1_k[K_W-1]) begin
                r_out_cov <= '0;
            end else if (w_round[REG_W+1:REG_W] != 2'b00) begin
                r_out_cov <= '1;
            end else begin
                r_out_cov <= w_round[REG_W-1:0];
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.covariance = r_out_cov;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_f1_valid)
        else $error("accepted request did not enter the first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_f1_valid) && $stable(r_b1_valid) && $stable(r_b1_p)))
        else $error("pipeline moved during an output stall");

    a_far_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_b1_valid && r_b1_far) |=> (o_out.covariance == '0))
        else $error("far point pair gave a nonzero covariance");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

/* src/ecov_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module ecov_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ecov_pkg::SQ_W-1:0]     i_value,
    input  logic                          i_half,
    output logic                          o_valid,
    output logic [ecov_pkg::ROOT_W-1:0]   o_root,
    output logic                          o_half
);
    import ecov_pkg::*;

    localparam int unsigned STEPS = ROOT_W;

    logic            r_valid [STEPS];
    logic            r_half  [STEPS];
    logic [SQ_W-1:0] r_v     [STEPS];
    logic [SQ_W-1:0] r_res   [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
        logic            w_valid;
        logic            w_half;
        logic [SQ_W-1:0] w_v;
        logic [SQ_W-1:0] w_res;
        logic [SQ_W-1:0] w_try;

        if (i == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_half  = i_half;
            assign w_v     = i_value;
            assign w_res   = '0;
        end else begin : g_next
            assign w_valid = r_valid[i-1];
            assign w_half  = r_half[i-1];
            assign w_v     = r_v[i-1];
            assign w_res   = r_res[i-1];
        end

        assign w_try = w_res + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_half[i] <= w_half;
                if (w_v >= w_try) begin
                    r_v[i]   <= w_v - w_try;
                    r_res[i] <= (w_res >> 1) + BIT;
                end else begin
                    r_v[i]   <= w_v;
                    r_res[i] <= w_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_half  = r_half[STEPS-1];
    assign o_root  = r_res[STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

/* src/ecov_reduce.sv */
// Scale distance by phi, detect far points, split exponent into k*ln2 + r.
`timescale 1ns / 1ps
`default_nettype none

module ecov_reduce #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [ecov_pkg::REG_W-1:0]    i_decay,
    input  logic                          i_valid,
    input  logic [ecov_pkg::DIST_W-1:0]   i_dist,
    output logic                          o_valid,
    output logic [ecov_pkg::FRAC_W-1:0]   o_r,
    output logic [ecov_pkg::K_W-1:0]      o_k,
    output logic                          o_far
);
    import ecov_pkg::*;

    localparam int unsigned FAR_SH = FAR_LOG2 + 2 * FRAC_BITS;
    localparam int unsigned Q_SH   = 2 * FRAC_BITS;

    logic                 r_t_valid;
    logic [T_W-1:0]       r_t;
    logic                 r_s_valid;
    logic                 r_s_far;
    logic [T32_W-1:0]     r_s_t32;
    logic [T_W+31:0]      w_t_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (i_en) begin
            r_t_valid <= i_valid;
            r_s_valid <= r_t_valid;
        end
    end

    // bring Q.2F to Q.32: multiply by 2^32, then drop 2F bits
    assign w_t_wide = {r_t, 32'b0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= T_W'(i_decay) * T_W'(i_dist);
            r_s_far <= (r_t >> FAR_SH) != '0;
            r_s_t32 <= w_t_wide[Q_SH +: T32_W];
        end
    end

    logic             r_valid [K_W];
    logic             r_far   [K_W];
    logic [T32_W-1:0] r_rem   [K_W];
    logic [K_W-1:0]   r_k     [K_W];

    // restoring division by ln2, one quotient bit per stage
    for (genvar i = 0; i < K_W; i++) begin : g_div
        localparam int unsigned J = K_W - 1 - i;
        localparam logic [T32_W-1:0] DIV = T32_W'(LN2_Q32) << J;
        logic             w_valid;
        logic             w_far;
        logic [T32_W-1:0] w_rem;
        logic [K_W-1:0]   w_k;

        if (i == 0) begin : g_first
            assign w_valid = r_s_valid;
            assign w_far   = r_s_far;
            assign w_rem   = r_s_t32;
            assign w_k     = '0;
        end else begin : g_next
            assign w_valid = r_valid[i-1];
            assign w_far   = r_far[i-1];
            assign w_rem   = r_rem[i-1];
            assign w_k     = r_k[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_far[i] <= w_far;
                if (w_rem >= DIV) begin
                    r_rem[i] <= w_rem - DIV;
                    r_k[i]   <= w_k | (K_W'(1) << J);
                end else begin
                    r_rem[i] <= w_rem;
                    r_k[i]   <= w_k;
                end
            end
        end
    end

    assign o_valid = r_valid[K_W-1];
    assign o_far   = r_far[K_W-1];
    assign o_k     = r_k[K_W-1];
    assign o_r     = r_rem[K_W-1][FRAC_W-1:0];

endmodule

`default_nettype wire

/* src/ecov_series.sv */
// Taylor series of exp(-r) in Q.32, three stages per term, then clamp to [0, 1.0].
`timescale 1ns / 1ps
`default_nettype none

module ecov_series (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ecov_pkg::FRAC_W-1:0]   i_r,
    input  logic [ecov_pkg::K_W-1:0]      i_k,
    input  logic                          i_far,
    output logic                          o_valid,
    output logic [ecov_pkg::E_W-1:0]      o_e,
    output logic [ecov_pkg::K_W-1:0]      o_k,
    output logic                          o_far
);
    import ecov_pkg::*;

    localparam int unsigned PROD_W = E_W + FRAC_W;

    logic                    r_c_valid [TERMS];
    logic                    r_c_far   [TERMS];
    logic [K_W-1:0]          r_c_k     [TERMS];
    logic [FRAC_W-1:0]       r_c_r     [TERMS];
    logic [E_W-1:0]          r_c_term  [TERMS];
    logic signed [SUM_W-1:0] r_c_sum   [TERMS];

    for (genvar i = 0; i < TERMS; i++) begin : g_term
        localparam int unsigned N = i + 1;
        // floor(2^32 / n); estimate is low by at most one
        localparam logic [E_W-1:0] RECIP = E_W'((64'd1 << 32) / N);

        logic                    w_valid;
        logic                    w_far;
        logic [K_W-1:0]          w_k;
        logic [FRAC_W-1:0]       w_r;
        logic [E_W-1:0]          w_term;
        logic signed [SUM_W-1:0] w_sum;

        logic                    r_a_valid, r_b_valid;
        logic                    r_a_far, r_b_far;
        logic [K_W-1:0]          r_a_k, r_b_k;
        logic [FRAC_W-1:0]       r_a_r, r_b_r;
        logic signed [SUM_W-1:0] r_a_sum, r_b_sum;
        logic [FRAC_W-1:0]       r_a_x, r_b_x;
        logic [FRAC_W-1:0]       r_b_q;

        logic [PROD_W-1:0]       w_prod;
        logic [PROD_W-1:0]       w_qprod;
        logic [SUM_W-1:0]        w_qn;
        logic [SUM_W-1:0]        w_rem;
        logic [FRAC_W-1:0]       w_q;
        logic signed [SUM_W-1:0] w_q_s;

        if (i == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_far   = i_far;
            assign w_k     = i_k;
            assign w_r     = i_r;
            assign w_term  = ONE_Q32;
            assign w_sum   = SUM_W'(ONE_Q32);
        end else begin : g_next
            assign w_valid = r_c_valid[i-1];
            assign w_far   = r_c_far[i-1];
            assign w_k     = r_c_k[i-1];
            assign w_r     = r_c_r[i-1];
            assign w_term  = r_c_term[i-1];
            assign w_sum   = r_c_sum[i-1];
        end

        assign w_prod  = PROD_W'(w_term) * PROD_W'(w_r);
        assign w_qprod = PROD_W'(r_a_x) * PROD_W'(RECIP);
        assign w_qn    = SUM_W'(r_b_q) * SUM_W'(N);
        assign w_rem   = SUM_W'(r_b_x) - w_qn;
        assign w_q     = (w_rem >= SUM_W'(N)) ? r_b_q + FRAC_W'(1) : r_b_q;
        assign w_q_s   = $signed(SUM_W'(w_q));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_valid    <= 1'b0;
                r_b_valid    <= 1'b0;
                r_c_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_a_valid    <= w_valid;
                r_b_valid    <= r_a_valid;
                r_c_valid[i] <= r_b_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_far  <= w_far;
                r_a_k    <= w_k;
                r_a_r    <= w_r;
                r_a_sum  <= w_sum;
                r_a_x    <= w_prod[2*FRAC_W-1:FRAC_W];

                r_b_far  <= r_a_far;
                r_b_k    <= r_a_k;
                r_b_r    <= r_a_r;
                r_b_sum  <= r_a_sum;
                r_b_x    <= r_a_x;
                r_b_q    <= w_qprod[2*FRAC_W-1:FRAC_W];

                r_c_far[i]  <= r_b_far;
                r_c_k[i]    <= r_b_k;
                r_c_r[i]    <= r_b_r;
                r_c_term[i] <= E_W'(w_q);
                // odd terms subtract
                if (N % 2 == 1) begin
                    r_c_sum[i] <= r_b_sum - w_q_s;
                end else begin
                    r_c_sum[i] <= r_b_sum + w_q_s;
                end
            end
        end
    end

    logic                    r_valid;
    logic                    r_far;
    logic [K_W-1:0]          r_k;
    logic [E_W-1:0]          r_e;
    logic signed [SUM_W-1:0] w_last;

    assign w_last = r_c_sum[TERMS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_c_valid[TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_far <= r_c_far[TERMS-1];
            r_k   <= r_c_k[TERMS-1];
            if (w_last < 0) begin
                r_e <= '0;
            end else if (w_last > $signed(SUM_W'(ONE_Q32))) begin
                r_e <= ONE_Q32;
            end else begin
                r_e <= w_last[E_W-1:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_far   = r_far;
    assign o_k     = r_k;
    assign o_e     = r_e;

endmodule

`default_nettype wire
